### src/wpmc_pkg.sv
`timescale 1ns / 1ps

package wpmc_pkg;

    // window geometry
    localparam int SIDE           = 7;
    localparam int PIX_W          = 8;
    localparam int ROW_W          = SIDE * PIX_W;
    localparam int WINDOW_DEFAULT = 7;

    // arithmetic widths, sized for the largest domain
    localparam int COEF_W   = 16;
    localparam int WSUM_W   = 24;
    localparam int ROWSUM_W = 11;
    localparam int SUM_W    = 14;
    localparam int N_W      = 6;
    localparam int CMP1_W   = 31;
    localparam int CMP2_W   = 16;
    localparam int FRAC_W   = 16;

    // configuration register indexes
    localparam int          CFG_ADDR_W         = 1;
    localparam int          CFG_DATA_W         = 8;
    localparam logic [0:0]  REG_DIFF_THRESHOLD = 1'b0;
    localparam logic [0:0]  REG_MAX_OFFSET     = 1'b1;

    localparam logic [7:0] DIFF_THRESHOLD_RESET = 8'd1;
    localparam logic [7:0] MAX_OFFSET_RESET     = 8'd40;

    // output codes
    localparam logic [7:0] MASK_PEAK = 8'd0;
    localparam logic [7:0] MASK_KEEP = 8'd255;

    // gaussian coefficients, unsigned q0.16, symmetric
    localparam logic [COEF_W-1:0] GAUSS_Q16 [SIDE][SIDE] = '{
        '{16'd55,  16'd197,  16'd424,  16'd547,  16'd424,  16'd197,  16'd55},
        '{16'd197, 16'd706,  16'd1518, 16'd1960, 16'd1518, 16'd706,  16'd197},
        '{16'd424, 16'd1518, 16'd3264, 16'd4213, 16'd3264, 16'd1518, 16'd424},
        '{16'd547, 16'd1960, 16'd4213, 16'd5437, 16'd4213, 16'd1960, 16'd547},
        '{16'd424, 16'd1518, 16'd3264, 16'd4213, 16'd3264, 16'd1518, 16'd424},
        '{16'd197, 16'd706,  16'd1518, 16'd1960, 16'd1518, 16'd706,  16'd197},
        '{16'd55,  16'd197,  16'd424,  16'd547,  16'd424,  16'd197,  16'd55}
    };

    // per-row partial results
    typedef struct packed {
        logic [WSUM_W-1:0]   wsum;
        logic [ROWSUM_W-1:0] sum;
        logic [PIX_W-1:0]    max;
    } row_res_t;

endpackage

### src/wpmc_row.sv
`timescale 1ns / 1ps

module wpmc_row #(
    parameter int ROW    = 0,
    parameter int WINDOW = wpmc_pkg::WINDOW_DEFAULT
) (
    input  logic [wpmc_pkg::ROW_W-1:0] row,
    output wpmc_pkg::row_res_t         res
);
    import wpmc_pkg::*;

    localparam int OFF    = (SIDE - WINDOW) / 2;
    localparam bit ROW_IN = (ROW >= OFF) && (ROW < OFF + WINDOW);

    // weighted row sum plus pixel sum and max over the domain columns
    always_comb
    begin
        logic [PIX_W-1:0] p;
        res = '0;
        for (int c = 0; c < SIDE; c++)
        begin
            p = row[c*PIX_W +: PIX_W];
            res.wsum = res.wsum + WSUM_W'(p) * WSUM_W'(GAUSS_Q16[ROW][c]);
            if (ROW_IN && (c >= OFF) && (c < OFF + WINDOW))
            begin
                res.sum = res.sum + ROWSUM_W'(p);
                if (p > res.max)
                begin
                    res.max = p;
                end
            end
        end
    end

endmodule

### src/window_peak_mask_classifier.sv
`timescale 1ns / 1ps

// window peak mask classifier
// s_tdata carries one 7x7 window of 8-bit pixels, seven rows of 56 bits,
// row 0 in the low bits and column 0 in the low byte of each row.
// m_tdata carries the mask pixel: 0 marks a peak, 255 keeps the pixel.
// the cfg port writes diff_threshold (index 0) and max_offset (index 1);
// only write while no transaction is in flight.
// three registered stages lead from an accepted input to m_tvalid: row reduction,
// window reduction, then the scaled compares into the output register.
// one window per cycle while not stalled; every stage is a registered step.
// reset empties all three stages and loads diff_threshold 1, max_offset 40.
// when m_tready is low the output register holds its transaction and the
// upstream stages fill; s_tready drops only once all three stages are full,
// so nothing is dropped or repeated.
module window_peak_mask_classifier #(
    parameter int WINDOW = wpmc_pkg::WINDOW_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // win_row0, win_row1, ... win_row6
    input  logic [7*wpmc_pkg::ROW_W-1:0]    s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mask_pixel
    output logic [7:0]                      m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [wpmc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wpmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import wpmc_pkg::*;

    // domain side limited to one through the full window
    localparam int EFF_WIN = (WINDOW < 1) ? 1 : ((WINDOW > SIDE) ? SIDE : WINDOW);
    localparam int N       = EFF_WIN * EFF_WIN;

    logic [7:0] diff_threshold_reg, diff_threshold_next;
    logic [7:0] max_offset_reg, max_offset_next;

    logic       v1_reg, v2_reg, v3_reg;
    logic       ready1, ready2, ready3;
    row_res_t   rows_next [SIDE];
    row_res_t   rows_reg  [SIDE];
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PIX_W-1:0]  max_reg, max_next;
    logic [7:0]        mask_reg, mask_next;

    logic [CMP1_W-1:0] lhs1, rhs1;
    logic [CMP2_W-1:0] lhs2, rhs2;

    // configuration writes
    always_comb
    begin
        diff_threshold_next = diff_threshold_reg;
        max_offset_next     = max_offset_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_DIFF_THRESHOLD: diff_threshold_next = cfg_wdata;
                REG_MAX_OFFSET:     max_offset_next     = cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_threshold_reg <= DIFF_THRESHOLD_RESET;
            max_offset_reg     <= MAX_OFFSET_RESET;
        end
        else
        begin
            diff_threshold_reg <= diff_threshold_next;
            max_offset_reg     <= max_offset_next;
        end
    end

    // stage advance: a stage takes new data when empty or draining
    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= s_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: per-row reduction
    for (genvar r = 0; r < SIDE; r++)
    begin : g_row
        wpmc_row #(
            .ROW    (r),
            .WINDOW (EFF_WIN)
        ) u_row (
            .row (s_tdata[r*ROW_W +: ROW_W]),
            .res (rows_next[r])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            rows_reg <= rows_next;
        end
    end

    // stage 2: combine the rows
    always_comb
    begin
        wsum_next = '0;
        sum_next  = '0;
        max_next  = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            wsum_next = wsum_next + rows_reg[r].wsum;
            sum_next  = sum_next + SUM_W'(rows_reg[r].sum);
            if (rows_reg[r].max > max_next)
            begin
                max_next = rows_reg[r].max;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            wsum_reg <= wsum_next;
            sum_reg  <= sum_next;
            max_reg  <= max_next;
        end
    end

    // stage 3: exact compares with the average scaled by n
    always_comb
    begin
        lhs1 = CMP1_W'(wsum_reg) * CMP1_W'(N);
        rhs1 = (CMP1_W'(sum_reg) + CMP1_W'(diff_threshold_reg) * CMP1_W'(N)) << FRAC_W;
        lhs2 = CMP2_W'(max_reg) * CMP2_W'(2 * N);
        rhs2 = CMP2_W'(sum_reg) + CMP2_W'(max_offset_reg) * CMP2_W'(2 * N);
        mask_next = ((lhs1 > rhs1) || (lhs2 > rhs2)) ? MASK_PEAK : MASK_KEEP;
    end

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            mask_reg <= mask_next;
        end
    end

    assign m_tdata  = mask_reg;
    assign m_tvalid = v3_reg;

endmodule

### src/wpmc_checker.sv
`timescale 1ns / 1ps

module wpmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic [7:0] m_tdata,
    input logic       m_tvalid,
    input logic       m_tready
);
    import wpmc_pkg::*;

    // the mask only ever carries one of its two codes
    a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == MASK_PEAK || m_tdata == MASK_KEEP))
        else $error("mask pixel is neither peak nor keep");

    // input backpressure only comes from a stalled output
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output transaction changed");

    // with the output draining, the input is always taken
    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input not ready while output drains");

endmodule

bind window_peak_mask_classifier wpmc_checker u_wpmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

### verif/tb_top.sv
`timescale 1ns / 1ps

// tracks expected mask pixels and checks the classifier output against them
class mask_scoreboard;
    logic [7:0] expected_masks[$];
    int         errors;
    int         domain_side;
    int         domain_first;

    function new(int window);
        domain_side  = (window < 1) ? 1 : ((window > wpmc_pkg::SIDE) ? wpmc_pkg::SIDE : window);
        domain_first = (wpmc_pkg::SIDE - domain_side) / 2;
        errors       = 0;
    endfunction

    // weighted sum over all 49 pixels, sum and max over the centered domain
    function logic [7:0] classify(input logic [7*wpmc_pkg::ROW_W-1:0] win,
                                  input logic [7:0] thr, input logic [7:0] off);
        longint unsigned wsum;
        longint unsigned sum;
        longint unsigned mx;
        longint unsigned p;
        longint unsigned n;
        wsum = 0;
        sum  = 0;
        mx   = 0;
        for (int r = 0; r < wpmc_pkg::SIDE; r++)
        begin
            for (int c = 0; c < wpmc_pkg::SIDE; c++)
            begin
                p = win[r*wpmc_pkg::ROW_W + c*wpmc_pkg::PIX_W +: wpmc_pkg::PIX_W];
                wsum += longint'(wpmc_pkg::GAUSS_Q16[r][c]) * p;
                if (r >= domain_first && r < domain_first + domain_side &&
                    c >= domain_first && c < domain_first + domain_side)
                begin
                    sum += p;
                    if (p > mx)
                        mx = p;
                end
            end
        end
        n = longint'(domain_side) * longint'(domain_side);
        // exact integer forms of both peak tests
        if ((wsum * n > 64'd65536 * (sum + longint'(thr) * n)) ||
            (64'd2 * n * mx > sum + 64'd2 * n * longint'(off)))
            return wpmc_pkg::MASK_PEAK;
        return wpmc_pkg::MASK_KEEP;
    endfunction

    function void note_window(input logic [7*wpmc_pkg::ROW_W-1:0] win,
                              input logic [7:0] thr, input logic [7:0] off);
        expected_masks.push_back(classify(win, thr, off));
    endfunction

    function void check_mask(input logic [7:0] actual);
        logic [7:0] exp_mask;
        if (expected_masks.size() == 0)
        begin
            $display("%0t: mask transaction %0d arrived with no window pending",
                     $time, actual);
            errors++;
        end
        else
        begin
            exp_mask = expected_masks.pop_front();
            if (exp_mask !== actual)
            begin
                $display("%0t: mask mismatch, expected %0d actual %0d",
                         $time, exp_mask, actual);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_masks.size();
    endfunction
endclass

module tb_top;
    import wpmc_pkg::*;

    localparam int WIN_DOMAIN  = WINDOW_DEFAULT;
    localparam int PIPE_LAT    = 3;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 168;

    typedef logic [7*ROW_W-1:0] window_t;
    typedef enum int {SHAPE_NOISE, SHAPE_FLAT, SHAPE_BUMP, SHAPE_SPOT} shape_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    // win_row0, win_row1, ... win_row6
    window_t               s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // mask_pixel
    logic [7:0]            m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // register values as the block currently holds them
    logic [7:0] thr_now = DIFF_THRESHOLD_RESET;
    logic [7:0] off_now = MAX_OFFSET_RESET;

    int tx_idle_pct = 30;
    int rx_idle_pct = 30;
    int rx_stall    = 0;

    mask_scoreboard sb = new(WIN_DOMAIN);

    window_peak_mask_classifier #(
        .WINDOW(WIN_DOMAIN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // overall time limit
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // output side: check each transaction, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_mask(m_tdata);
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < rx_idle_pct)
            begin
                rx_stall = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic window_t with_pixel(window_t w, int r, int c, int v);
        w[r*ROW_W + c*PIX_W +: PIX_W] = (v > 255) ? 8'hFF : v[7:0];
        return w;
    endfunction

    function automatic window_t fill(logic [7:0] v);
        window_t w;
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                w[r*ROW_W + c*PIX_W +: PIX_W] = v;
        return w;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < tx_idle_pct)
            return $urandom_range(1, 15);
        return 0;
    endfunction

    // random window of the given shape
    function automatic window_t make_window(shape_t shape);
        window_t w;
        int      base;
        int      spread;
        int      amp;
        int      cr;
        int      cc;
        int      d;
        w      = '0;
        base   = $urandom_range(0, 180);
        spread = $urandom_range(0, 12);
        amp    = $urandom_range(0, 255);
        cr     = $urandom_range(2, 4);
        cc     = $urandom_range(2, 4);
        case (shape)
            SHAPE_NOISE:
                for (int r = 0; r < SIDE; r++)
                    w[r*ROW_W +: ROW_W] = ROW_W'({$urandom, $urandom});
            SHAPE_FLAT:
                for (int r = 0; r < SIDE; r++)
                    for (int c = 0; c < SIDE; c++)
                        w = with_pixel(w, r, c, base + $urandom_range(0, spread));
            SHAPE_BUMP:
                for (int r = 0; r < SIDE; r++)
                    for (int c = 0; c < SIDE; c++)
                    begin
                        d = (r > cr ? r - cr : cr - r);
                        d = (c > cc ? c - cc : cc - c) > d ? (c > cc ? c - cc : cc - c) : d;
                        w = with_pixel(w, r, c, base + $urandom_range(0, spread) +
                                                (d < 3 ? (amp >> d) : 0));
                    end
            default:
            begin
                base = $urandom_range(0, 60);
                for (int r = 0; r < SIDE; r++)
                    for (int c = 0; c < SIDE; c++)
                        w = with_pixel(w, r, c, base + $urandom_range(0, spread));
                w = with_pixel(w, $urandom_range(0, 6), $urandom_range(0, 6), amp);
            end
        endcase
        return w;
    endfunction

    // hold one window until accepted, then an optional gap
    task automatic send_window(window_t w, int gap);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_window(w, thr_now, off_now);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for the pipeline to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // both registers, one per clock
    task automatic write_thresholds(logic [7:0] thr, logic [7:0] off);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_DIFF_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_addr  <= REG_MAX_OFFSET;
        cfg_wdata <= off;
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_now = thr;
        off_now = off;
    endtask

    // extremes, corner spikes, bit patterns and the max-test boundary
    task automatic run_directed();
        window_t w;
        send_window(fill(8'h00), pick_gap());
        send_window(fill(8'hFF), pick_gap());
        send_window(with_pixel(fill(8'h00), 3, 3, 255), pick_gap());
        send_window(with_pixel(fill(8'h00), 0, 0, 255), pick_gap());
        send_window(with_pixel(fill(8'h00), 0, 6, 255), pick_gap());
        send_window(with_pixel(fill(8'h00), 6, 0, 255), pick_gap());
        send_window(with_pixel(fill(8'h00), 6, 6, 255), pick_gap());
        send_window(fill(8'd100), pick_gap());
        send_window(with_pixel(fill(8'd100), 3, 3, 200), pick_gap());
        send_window(with_pixel(fill(8'hFF), 3, 3, 0), pick_gap());
        send_window(fill(8'hAA), pick_gap());
        send_window(fill(8'h55), pick_gap());
        // just below and just above the max test at zero background
        send_window(with_pixel(fill(8'h00), 0, 0, 40), pick_gap());
        send_window(with_pixel(fill(8'h00), 0, 0, 41), pick_gap());
        // alternating rows, then alternating columns
        w = '0;
        for (int r = 0; r < SIDE; r += 2)
            w[r*ROW_W +: ROW_W] = '1;
        send_window(w, pick_gap());
        w = '0;
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c += 2)
                w = with_pixel(w, r, c, 255);
        send_window(w, pick_gap());
        // smooth centered bump on a mid background
        w = fill(8'd60);
        for (int r = 2; r <= 4; r++)
            for (int c = 2; c <= 4; c++)
                w = with_pixel(w, r, c, (r == 3 && c == 3) ? 180 : 110);
        send_window(w, pick_gap());
    endtask

    initial
    begin
        shape_t     shape;
        int         roll;
        logic [7:0] thr_next;
        logic [7:0] off_next;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            // idling density per phase, none in the last one
            if (ph == N_PHASES - 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (ph > 0)
            begin
                case ($urandom_range(0, 3))
                    0: tx_idle_pct = 0;
                    1: tx_idle_pct = 10;
                    2: tx_idle_pct = 30;
                    default: tx_idle_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: rx_idle_pct = 0;
                    1: rx_idle_pct = 10;
                    2: rx_idle_pct = 30;
                    default: rx_idle_pct = 60;
                endcase
            end
            // threshold settings, the first phase runs on reset values
            if (ph > 0)
            begin
                case (ph)
                    1: begin thr_next = 8'd0;   off_next = 8'd0;   end
                    2: begin thr_next = 8'd255; off_next = 8'd255; end
                    3: begin thr_next = 8'd0;   off_next = 8'd255; end
                    4: begin thr_next = 8'd255; off_next = 8'd0;   end
                    7: begin thr_next = DIFF_THRESHOLD_RESET; off_next = MAX_OFFSET_RESET; end
                    default:
                    begin
                        thr_next = 8'($urandom_range(0, 16));
                        off_next = 8'($urandom_range(0, 255));
                    end
                endcase
                write_thresholds(thr_next, off_next);
            end
            if (ph == 0)
                run_directed();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    shape = SHAPE_NOISE;
                else if (roll < 45)
                    shape = SHAPE_FLAT;
                else if (roll < 85)
                    shape = SHAPE_BUMP;
                else
                    shape = SHAPE_SPOT;
                send_window(make_window(shape), pick_gap());
            end
            settle();
        end
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
